// File: rtl/maze_backtracker_step_macros.svh
// ----------------------------------------------------------------------------
// maze_backtracker_step_macros.svh
// Assertion macros of the maze backtracker checker
// ----------------------------------------------------------------------------
`ifndef MAZE_BACKTRACKER_STEP_MACROS_SVH
`define MAZE_BACKTRACKER_STEP_MACROS_SVH

// concurrent check, quiet while reset is held
`define MBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also looks at reset cycles
`define MBT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types, codes and wall helpers of the maze backtracker
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

  // default grid size
  localparam int GRID_WIDTH_DEF  = 16;
  localparam int GRID_HEIGHT_DEF = 16;

  // cell entry: visited mark over four wall bits
  localparam int ENTRY_W = 5;
  localparam logic [3:0] WALLS_ALL = 4'hF;

  // wall bits
  localparam logic [3:0] WALL_N = 4'b0001;
  localparam logic [3:0] WALL_S = 4'b0010;
  localparam logic [3:0] WALL_E = 4'b0100;
  localparam logic [3:0] WALL_W = 4'b1000;

  // input modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_MOVED = 3'd0,
    ST_BACK  = 3'd1,
    ST_DONE  = 3'd2,
    ST_IDLE  = 3'd3,
    ST_READ  = 3'd4
  } status_t;

  // neighbor directions in candidate order
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_t;

  // neighbor choice
  typedef struct packed {
    logic any;
    dir_t dir;
  } pick_t;

  // wall of the walker's cell toward a direction
  function automatic logic [3:0] here_wall(input dir_t dir);
    logic [3:0] w;
    unique case (dir)
      DIR_N:   w = WALL_N;
      DIR_S:   w = WALL_S;
      DIR_W:   w = WALL_W;
      DIR_E:   w = WALL_E;
      default: w = '0;
    endcase
    return w;
  endfunction

  // wall of the neighbor facing back
  function automatic logic [3:0] there_wall(input dir_t dir);
    logic [3:0] w;
    unique case (dir)
      DIR_N:   w = WALL_S;
      DIR_S:   w = WALL_N;
      DIR_W:   w = WALL_E;
      DIR_E:   w = WALL_W;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mbt_ram.sv
// ----------------------------------------------------------------------------
// mbt_ram
// Simple dual-port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_ram #(
  parameter int DEPTH = mbt_pkg::GRID_WIDTH_DEF * mbt_pkg::GRID_HEIGHT_DEF,
  parameter int WIDTH = mbt_pkg::ENTRY_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/mbt_pick.sv
// ----------------------------------------------------------------------------
// mbt_pick
// Chooses one open neighbor: random value modulo the open count,
// counted in the order north, south, west, east
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_pick (
  input  logic [3:0]     mask,
  input  logic [7:0]     rnd,
  output mbt_pkg::pick_t pick
);

  import mbt_pkg::*;

  logic [2:0] cnt;
  logic [3:0] sum4;
  logic [2:0] sum2;
  logic [1:0] mod3;
  logic [1:0] k;
  logic [2:0] pre;
  dir_t       dir_sel;

  // open count
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      cnt = cnt + {2'b00, mask[i]};
    end
  end

  // rnd mod 3 by summing base-4 digits
  always_comb begin
    sum4 = {2'b00, rnd[1:0]} + {2'b00, rnd[3:2]} + {2'b00, rnd[5:4]} + {2'b00, rnd[7:6]};
    sum2 = {1'b0, sum4[1:0]} + {1'b0, sum4[3:2]};
    if (sum2 >= 3'd6) begin
      mod3 = 2'(sum2 - 3'd6);
    end else if (sum2 >= 3'd3) begin
      mod3 = 2'(sum2 - 3'd3);
    end else begin
      mod3 = sum2[1:0];
    end
  end

  // rank of the chosen candidate
  always_comb begin
    case (cnt)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3;
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
  end

  // k-th open direction
  always_comb begin
    pre     = '0;
    dir_sel = DIR_N;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && pre == {1'b0, k}) begin
        dir_sel = dir_t'(2'(i));
      end
      pre = pre + {2'b00, mask[i]};
    end
  end

  assign pick.any = (cnt != 3'd0);
  assign pick.dir = dir_sel;

endmodule

`default_nettype wire

// File: rtl/maze_backtracker_step.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Maze generator by randomized depth-first search over a grid of cells
// ----------------------------------------------------------------------------
// Usage: one input word (mode, random value, cell index) gives exactly one
// result word (status, walker cell, walls, visited mark, busy). Both sides
// use valid/stall; in_stall is high whenever the block is working on a word.
// A start while idle runs a clearing pass over every cell of the cell
// memory, then returns its word. A generation step reads the walker's cell
// and its four neighbors one by one from the cell memory, decides, then
// writes the cell (and the new cell on a move), then returns its word. A new
// word is taken the cycle after the result is loaded into the output
// register, even while that result is stalled; the next result then waits
// in the block until the output is taken. Reset also runs the clearing pass
// with in_stall high and out_valid low.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_backtracker_step #(
  parameter int GRID_WIDTH  = mbt_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = mbt_pkg::GRID_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_random_value,
  input  logic [7:0] in_cell_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_walker_pos,
  output logic [3:0] out_cell_walls,
  output logic       out_cell_visited,
  output logic       out_busy_res
);

  import mbt_pkg::*;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW  = $clog2(CELL_COUNT);
  localparam int RW  = $clog2(GRID_HEIGHT);
  localparam int CLW = $clog2(GRID_WIDTH);
  localparam int DW  = $clog2(CELL_COUNT + 1);
  localparam int SW  = CW + RW + CLW;

  localparam logic [CW-1:0]  CELL_LAST  = CW'(CELL_COUNT - 1);
  localparam logic [CW-1:0]  ROW_STEP   = CW'(GRID_WIDTH);
  localparam logic [RW-1:0]  ROW_LAST   = RW'(GRID_HEIGHT - 1);
  localparam logic [CLW-1:0] COL_LAST   = CLW'(GRID_WIDTH - 1);
  localparam logic [DW-1:0]  DEPTH_FULL = DW'(CELL_COUNT);
  localparam logic [2:0]     G_LAST     = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GATHER,
    S_DECIDE,
    S_WR_NX,
    S_POP,
    S_RDCELL,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           g_r, g_nxt;
  logic [CW-1:0]        clr_r, clr_nxt;
  logic                 clr_emit_r, clr_emit_nxt;
  logic [CW-1:0]        cur_r, cur_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CLW-1:0]       col_r, col_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic                 gen_r, gen_nxt;
  logic [7:0]           rnd_r, rnd_nxt;
  logic [ENTRY_W-1:0]   ent_r [5];
  logic [ENTRY_W-1:0]   ent_nxt [5];
  logic [3:0]           nxw_r, nxw_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [3:0]           res_walls_r, res_walls_nxt;
  logic                 res_vis_r, res_vis_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [7:0]           out_cell_r, out_cell_nxt;
  logic [3:0]           out_walls_r, out_walls_nxt;
  logic                 out_vis_r, out_vis_nxt;
  logic                 out_busy_r, out_busy_nxt;

  logic [3:0]           nb_valid;
  logic [CW-1:0]        nb_addr [4];
  logic [3:0]           nb_mask;
  pick_t                pick;
  logic [2:0]           g_dec;
  logic [2:0]           pick_ent;
  logic [DW-1:0]        depth_dec;
  logic                 accept;
  logic                 out_free;

  logic                 cell_wr_en;
  logic [CW-1:0]        cell_wr_addr;
  logic [ENTRY_W-1:0]   cell_wr_data;
  logic                 cell_rd_en;
  logic [CW-1:0]        cell_rd_addr;
  logic [ENTRY_W-1:0]   cell_rd_data;
  logic                 stk_wr_en;
  logic [CW-1:0]        stk_wr_addr;
  logic [SW-1:0]        stk_wr_data;
  logic                 stk_rd_en;
  logic [CW-1:0]        stk_rd_addr;
  logic [SW-1:0]        stk_rd_data;

  // cell store: visited mark and walls per cell
  mbt_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (ENTRY_W)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_wr_en),
    .wr_addr (cell_wr_addr),
    .wr_data (cell_wr_data),
    .rd_en   (cell_rd_en),
    .rd_addr (cell_rd_addr),
    .rd_data (cell_rd_data)
  );

  // path stack: cell, row and column of each pushed cell
  mbt_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (SW)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  // neighbor choice
  mbt_pick u_pick (
    .mask (nb_mask),
    .rnd  (rnd_r),
    .pick (pick)
  );

  // neighbors of the walker, north, south, west, east
  always_comb begin
    nb_valid[0] = (row_r != '0);
    nb_valid[1] = (row_r != ROW_LAST);
    nb_valid[2] = (col_r != '0);
    nb_valid[3] = (col_r != COL_LAST);
    nb_addr[0]  = cur_r - ROW_STEP;
    nb_addr[1]  = cur_r + ROW_STEP;
    nb_addr[2]  = cur_r - CW'(1);
    nb_addr[3]  = cur_r + CW'(1);
    for (int i = 0; i < 4; i++) begin
      nb_mask[i] = nb_valid[i] & ~ent_r[i + 1][ENTRY_W-1];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign g_dec     = g_r - 3'd1;
  assign pick_ent  = {1'b0, pick.dir} + 3'd1;
  assign depth_dec = depth_r - DW'(1);

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    g_nxt          = g_r;
    clr_nxt        = clr_r;
    clr_emit_nxt   = clr_emit_r;
    cur_nxt        = cur_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    depth_nxt      = depth_r;
    gen_nxt        = gen_r;
    rnd_nxt        = rnd_r;
    ent_nxt        = ent_r;
    nxw_nxt        = nxw_r;
    res_status_nxt = res_status_r;
    res_walls_nxt  = res_walls_r;
    res_vis_nxt    = res_vis_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_cell_nxt   = out_cell_r;
    out_walls_nxt  = out_walls_r;
    out_vis_nxt    = out_vis_r;
    out_busy_nxt   = out_busy_r;

    cell_wr_en   = 1'b0;
    cell_wr_addr = cur_r;
    cell_wr_data = '0;
    cell_rd_en   = 1'b0;
    cell_rd_addr = cur_r;
    stk_wr_en    = 1'b0;
    stk_wr_addr  = depth_r[CW-1:0];
    stk_wr_data  = {cur_r, row_r, col_r};
    stk_rd_en    = 1'b0;
    stk_rd_addr  = depth_dec[CW-1:0];

    unique case (state_r)
      // sweep every cell to four walls, unvisited
      S_CLEAR: begin
        cell_wr_en   = 1'b1;
        cell_wr_addr = clr_r;
        cell_wr_data = {1'b0, WALLS_ALL};
        if (clr_r == CELL_LAST) begin
          state_nxt = clr_emit_r ? S_EMIT : S_IDLE;
        end else begin
          clr_nxt = clr_r + CW'(1);
        end
      end

      // take a word and decode the mode
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_IDLE;
          res_walls_nxt  = '0;
          res_vis_nxt    = 1'b0;
          state_nxt      = S_EMIT;
          unique case (in_mode)
            MODE_START: begin
              if (!gen_r) begin
                gen_nxt      = 1'b1;
                depth_nxt    = '0;
                clr_nxt      = '0;
                clr_emit_nxt = 1'b1;
                state_nxt    = S_CLEAR;
              end
            end
            MODE_STEP: begin
              if (gen_r) begin
                rnd_nxt   = in_random_value;
                g_nxt     = '0;
                state_nxt = S_GATHER;
              end
            end
            MODE_READ: begin
              res_status_nxt = ST_READ;
              if (32'(in_cell_index) < 32'(CELL_COUNT)) begin
                cell_rd_en   = 1'b1;
                cell_rd_addr = CW'(in_cell_index);
                state_nxt    = S_RDCELL;
              end
            end
            default: ;
          endcase
        end
      end

      // read the walker's cell then each neighbor, one per cycle
      S_GATHER: begin
        if (g_r != G_LAST) begin
          cell_rd_en = 1'b1;
          if (g_r != 3'd0 && nb_valid[g_dec[1:0]]) begin
            cell_rd_addr = nb_addr[g_dec[1:0]];
          end
        end
        if (g_r != 3'd0) begin
          ent_nxt[g_dec] = cell_rd_data;
        end
        if (g_r == G_LAST) begin
          state_nxt = S_DECIDE;
        end else begin
          g_nxt = g_r + 3'd1;
        end
      end

      // mark the walker visited, then move, pop or finish
      S_DECIDE: begin
        cell_wr_en   = 1'b1;
        cell_wr_addr = cur_r;
        if (pick.any) begin
          cell_wr_data = {1'b1, ent_r[0][3:0] & ~here_wall(pick.dir)};
          if (depth_r < DEPTH_FULL) begin
            stk_wr_en = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
          cur_nxt = nb_addr[pick.dir];
          unique case (pick.dir)
            DIR_N:   row_nxt = row_r - RW'(1);
            DIR_S:   row_nxt = row_r + RW'(1);
            DIR_W:   col_nxt = col_r - CLW'(1);
            DIR_E:   col_nxt = col_r + CLW'(1);
            default: ;
          endcase
          nxw_nxt        = ent_r[pick_ent][3:0] & ~there_wall(pick.dir);
          res_status_nxt = ST_MOVED;
          state_nxt      = S_WR_NX;
        end else begin
          cell_wr_data = {1'b1, ent_r[0][3:0]};
          if (depth_r != '0) begin
            stk_rd_en      = 1'b1;
            depth_nxt      = depth_dec;
            res_status_nxt = ST_BACK;
            state_nxt      = S_POP;
          end else begin
            gen_nxt        = 1'b0;
            res_status_nxt = ST_DONE;
            state_nxt      = S_EMIT;
          end
        end
      end

      // open the facing wall of the new cell
      S_WR_NX: begin
        cell_wr_en   = 1'b1;
        cell_wr_addr = cur_r;
        cell_wr_data = {1'b1, nxw_r};
        state_nxt    = S_EMIT;
      end

      // walker returns to the popped cell
      S_POP: begin
        {cur_nxt, row_nxt, col_nxt} = stk_rd_data;
        state_nxt                   = S_EMIT;
      end

      // read data back
      S_RDCELL: begin
        res_walls_nxt = cell_rd_data[3:0];
        res_vis_nxt   = cell_rd_data[ENTRY_W-1];
        state_nxt     = S_EMIT;
      end

      // load the output register once it is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_cell_nxt   = 8'(cur_r);
          out_walls_nxt  = res_walls_r;
          out_vis_nxt    = res_vis_r;
          out_busy_nxt   = gen_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      cur_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      depth_r     <= '0;
      gen_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_emit_r   <= clr_emit_nxt;
      cur_r        <= cur_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      depth_r      <= depth_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
      g_r          <= g_nxt;
      rnd_r        <= rnd_nxt;
      ent_r        <= ent_nxt;
      nxw_r        <= nxw_nxt;
      res_status_r <= res_status_nxt;
      res_walls_r  <= res_walls_nxt;
      res_vis_r    <= res_vis_nxt;
      out_status_r <= out_status_nxt;
      out_cell_r   <= out_cell_nxt;
      out_walls_r  <= out_walls_nxt;
      out_vis_r    <= out_vis_nxt;
      out_busy_r   <= out_busy_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_walker_pos   = out_cell_r;
  assign out_cell_walls   = out_walls_r;
  assign out_cell_visited = out_vis_r;
  assign out_busy_res     = out_busy_r;

endmodule

`default_nettype wire

// File: rtl/mbt_checker.sv
// ----------------------------------------------------------------------------
// mbt_checker
// Port-level checks of the maze backtracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "maze_backtracker_step_macros.svh"

module mbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [3:0] out_cell_walls,
  input logic       out_cell_visited,
  input logic       out_busy_res
);

  import mbt_pkg::*;

  // reset starts the clearing pass with no result shown
  `MBT_ASSERT_RST(a_reset_clears, !rst_n |=> in_stall && !out_valid, "reset did not hold input")

  // a stalled result word holds its status and busy flag
  `MBT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_busy_res), "stalled result changed")

  // walls and visited mark only come with read data
  `MBT_ASSERT(a_read_only_data, out_valid && out_status != ST_READ |-> out_cell_walls == 4'd0 && !out_cell_visited, "cell data outside a read")

  // finishing ends generation
  `MBT_ASSERT(a_done_idle, out_valid && out_status == ST_DONE |-> !out_busy_res, "finished while busy")

  // a move or a backtrack happens only while generating
  `MBT_ASSERT(a_step_busy, out_valid && (out_status == ST_MOVED || out_status == ST_BACK) |-> out_busy_res, "step result while not busy")

endmodule

bind maze_backtracker_step mbt_checker u_mbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_cell_walls   (out_cell_walls),
  .out_cell_visited (out_cell_visited),
  .out_busy_res     (out_busy_res)
);

`default_nettype wire
